/* rtl/ipd_pkg.sv */
`default_nettype none
package ipd_pkg;

  localparam int LANES   = 4;
  localparam int MAX_DIM = 4096;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int SUM_W   = PROD_W + $clog2(LANES) + 1;
  localparam int ACC_W   = 45;
  localparam int DIST_W  = 44;
  localparam int LV_W    = 3;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_ALL = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_G16 = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_G4  = MODE_W'(2);

  // 1.0 in Q.30
  localparam logic signed [ACC_W-1:0] ONE_Q30 = {{(ACC_W - 31){1'b0}}, 1'b1, 30'd0};

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [LANES-1:0]         lane_mask_t;

  typedef struct packed {
    lane_mask_t bnd;
    logic       last;
    logic       too_long;
  } s1_ctl_t;

  typedef struct packed {
    sum_t lo;
    sum_t hi;
    logic has_b;
    logic last;
    logic too_long;
  } s2_t;

endpackage
`default_nettype wire

/* rtl/ipd_in_if.sv */
`default_nettype none
interface ipd_in_if;
  logic                  valid;
  logic                  ready;
  logic signed [15:0]    a_lane0;
  logic signed [15:0]    a_lane1;
  logic signed [15:0]    a_lane2;
  logic signed [15:0]    a_lane3;
  logic signed [15:0]    b_lane0;
  logic signed [15:0]    b_lane1;
  logic signed [15:0]    b_lane2;
  logic signed [15:0]    b_lane3;
  logic [2:0]            lanes_valid;
  logic                  last;

  modport source (
    output valid, a_lane0, a_lane1, a_lane2, a_lane3,
    output b_lane0, b_lane1, b_lane2, b_lane3, lanes_valid, last,
    input  ready
  );
  modport sink (
    input  valid, a_lane0, a_lane1, a_lane2, a_lane3,
    input  b_lane0, b_lane1, b_lane2, b_lane3, lanes_valid, last,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/ipd_out_if.sv */
`default_nettype none
interface ipd_out_if;
  logic               valid;
  logic               ready;
  logic signed [43:0] distance;
  logic               too_long;

  modport source (output valid, distance, too_long, input ready);
  modport sink (input valid, distance, too_long, output ready);
endinterface
`default_nettype wire

/* rtl/ipd_cfg_if.sv */
`default_nettype none
interface ipd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] tail_mode;

  modport source (output valid, tail_mode, input ready);
  modport sink (input valid, tail_mode, output ready);
endinterface
`default_nettype wire

/* rtl/ipd_ctrl.sv */
`default_nettype none
module ipd_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_fire,
  input  wire logic [ipd_pkg::LV_W-1:0]      lanes_valid,
  input  wire logic                          last,
  input  wire logic [ipd_pkg::MODE_W-1:0]    mode,
  output      ipd_pkg::lane_mask_t           keep,
  output      ipd_pkg::s1_ctl_t              ctl_r
);

  logic [ipd_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [ipd_pkg::LV_W-1:0]  nlanes;
  logic [ipd_pkg::CNT_W:0]   pos [ipd_pkg::LANES];
  logic [ipd_pkg::CNT_W:0]   pos1 [ipd_pkg::LANES];
  logic [ipd_pkg::CNT_W-1:0] kcnt;
  ipd_pkg::lane_mask_t       bnd;
  logic                      item_ovf;

  always_comb begin
    nlanes = (lanes_valid > ipd_pkg::LV_W'(ipd_pkg::LANES)) ?
             ipd_pkg::LV_W'(ipd_pkg::LANES) : lanes_valid;
    kcnt     = '0;
    item_ovf = 1'b0;
    for (int i = 0; i < ipd_pkg::LANES; i++) begin
      pos[i]  = {1'b0, count_r} + (ipd_pkg::CNT_W + 1)'(i);
      pos1[i] = pos[i] + (ipd_pkg::CNT_W + 1)'(1);
      keep[i] = (i < int'(nlanes)) &&
                (pos[i] < (ipd_pkg::CNT_W + 1)'(ipd_pkg::MAX_DIM));
      item_ovf = item_ovf | ((i < int'(nlanes)) && !keep[i]);
      kcnt = kcnt + ipd_pkg::CNT_W'(keep[i]);
      // element closes a group when its 1-based index is a multiple of the group
      case (mode)
        ipd_pkg::MODE_G16: bnd[i] = keep[i] && (pos1[i][3:0] == 4'd0);
        ipd_pkg::MODE_G4:  bnd[i] = keep[i] && (pos1[i][1:0] == 2'd0);
        default:           bnd[i] = keep[i];
      endcase
    end
    count_nxt = last ? '0 : count_r + kcnt;
    ovf_nxt   = last ? 1'b0 : (ovf_r | item_ovf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (in_fire) begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctl_r.bnd      <= bnd;
      ctl_r.last     <= last;
      ctl_r.too_long <= ovf_r | item_ovf;
    end
  end

endmodule
`default_nettype wire

/* rtl/ipd_lane.sv */
`default_nettype none
module ipd_lane (
  input  wire logic           clk,
  input  wire logic           load,
  input  wire logic           keep,
  input  wire ipd_pkg::elem_t a,
  input  wire ipd_pkg::elem_t b,
  output      ipd_pkg::prod_t prod_r
);

  ipd_pkg::prod_t prod_nxt;

  // dropped or invalid lanes contribute zero
  assign prod_nxt = keep ? ipd_pkg::prod_t'(a * b) : '0;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/ipd_merge.sv */
`default_nettype none
module ipd_merge (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire ipd_pkg::prod_t   prod [ipd_pkg::LANES],
  input  wire ipd_pkg::s1_ctl_t ctl,
  output      ipd_pkg::s2_t     s2_r
);

  ipd_pkg::lane_mask_t le;
  logic                seen;
  ipd_pkg::sum_t       lo, hi;

  // lanes up to the last group boundary go to lo, the rest to hi
  always_comb begin
    seen = 1'b0;
    for (int i = ipd_pkg::LANES - 1; i >= 0; i--) begin
      seen  = seen | ctl.bnd[i];
      le[i] = seen;
    end
    lo = '0;
    hi = '0;
    for (int i = 0; i < ipd_pkg::LANES; i++) begin
      if (le[i]) begin
        lo = lo + ipd_pkg::sum_t'(prod[i]);
      end else begin
        hi = hi + ipd_pkg::sum_t'(prod[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_r.lo       <= lo;
      s2_r.hi       <= hi;
      s2_r.has_b    <= |ctl.bnd;
      s2_r.last     <= ctl.last;
      s2_r.too_long <= ctl.too_long;
    end
  end

endmodule
`default_nettype wire

/* rtl/ipd_accum.sv */
`default_nettype none
module ipd_accum (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    acc_fire,
  input  wire logic                    out_load,
  input  wire logic                    use_pend,
  input  wire ipd_pkg::s2_t            s2,
  output      logic signed [ipd_pkg::DIST_W-1:0] dist_r,
  output      logic                    tl_r
);

  ipd_pkg::acc_t comm_r, comm_nxt;
  ipd_pkg::acc_t pend_r, pend_nxt;
  ipd_pkg::acc_t cand_c_r, cand_p_r;
  logic          cand_tl_r;
  ipd_pkg::acc_t lo_x, hi_x, dist_full;

  always_comb begin
    lo_x = ipd_pkg::acc_t'(s2.lo);
    hi_x = ipd_pkg::acc_t'(s2.hi);
    if (s2.has_b) begin
      comm_nxt = comm_r + pend_r + lo_x;
      pend_nxt = hi_x;
    end else begin
      comm_nxt = comm_r;
      pend_nxt = pend_r + hi_x;
    end
    dist_full = ipd_pkg::ONE_Q30 - cand_c_r - cand_p_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comm_r <= '0;
      pend_r <= '0;
    end else if (acc_fire) begin
      if (s2.last) begin
        comm_r <= '0;
        pend_r <= '0;
      end else begin
        comm_r <= comm_nxt;
        pend_r <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire && s2.last) begin
      cand_c_r  <= comm_nxt;
      cand_p_r  <= use_pend ? pend_nxt : '0;
      cand_tl_r <= s2.too_long;
    end
    if (out_load) begin
      dist_r <= dist_full[ipd_pkg::DIST_W-1:0];
      tl_r   <= cand_tl_r;
    end
  end

endmodule
`default_nettype wire

/* rtl/inner_product_distance.sv */
`default_nettype none
// channel  dir  handshake        payload
// in_ch    in   valid / ready    a_lane0..3, b_lane0..3, lanes_valid, last
// out_ch   out  valid / ready    distance, too_long
// cfg_ch   in   valid / ready=1  tail_mode
//
// One item per cycle while out_ch does not stall; out_ch.valid is the output register flag.
// The rate is set by the accumulator add in the merge/accumulate stage.
// Reset (rst_n low, synchronous) clears sums, element count and tail_mode.
// Non-last items retire in the accumulator without out_ch; a last item waits there
// only while candidate and output registers are full and out_ch.ready is low, and
// the input stalls once both front stages are held behind it.
module inner_product_distance (
  input  wire logic clk,
  input  wire logic rst_n,
  ipd_in_if.sink    in_ch,
  ipd_out_if.source out_ch,
  ipd_cfg_if.sink   cfg_ch
);

  logic [ipd_pkg::MODE_W-1:0] tail_mode_r;
  logic v1_r, v1_nxt, v2_r, v2_nxt, cv_r, cv_nxt, ov_r, ov_nxt;
  logic in_fire, move12, acc_fire, cand_in, out_load, cand_free, s2_free, s1_free;
  logic use_pend;

  ipd_pkg::elem_t      a_arr [ipd_pkg::LANES];
  ipd_pkg::elem_t      b_arr [ipd_pkg::LANES];
  ipd_pkg::prod_t      prod  [ipd_pkg::LANES];
  ipd_pkg::lane_mask_t keep;
  ipd_pkg::s1_ctl_t    ctl;
  ipd_pkg::s2_t        s2;

  assign a_arr[0] = in_ch.a_lane0;
  assign a_arr[1] = in_ch.a_lane1;
  assign a_arr[2] = in_ch.a_lane2;
  assign a_arr[3] = in_ch.a_lane3;
  assign b_arr[0] = in_ch.b_lane0;
  assign b_arr[1] = in_ch.b_lane1;
  assign b_arr[2] = in_ch.b_lane2;
  assign b_arr[3] = in_ch.b_lane3;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_mode_r <= ipd_pkg::MODE_ALL;
    end else if (cfg_ch.valid) begin
      tail_mode_r <= cfg_ch.tail_mode;
    end
  end

  assign use_pend = !(tail_mode_r == ipd_pkg::MODE_G16 || tail_mode_r == ipd_pkg::MODE_G4);

  // pipeline flow: non-last items retire in the accumulator and never need out_ch
  always_comb begin
    out_load  = cv_r && (!ov_r || out_ch.ready);
    cand_free = !cv_r || out_load;
    acc_fire  = v2_r && (!s2.last || cand_free);
    cand_in   = acc_fire && s2.last;
    s2_free   = !v2_r || acc_fire;
    move12    = v1_r && s2_free;
    s1_free   = !v1_r || move12;
    in_fire   = in_ch.valid && s1_free;
    v1_nxt    = in_fire || (v1_r && !move12);
    v2_nxt    = move12 || (v2_r && !acc_fire);
    cv_nxt    = cand_in || (cv_r && !out_load);
    ov_nxt    = out_load || (ov_r && !out_ch.ready);
  end

  assign in_ch.ready  = s1_free;
  assign out_ch.valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      cv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      cv_r <= cv_nxt;
      ov_r <= ov_nxt;
    end
  end

  ipd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .lanes_valid (in_ch.lanes_valid),
    .last        (in_ch.last),
    .mode        (tail_mode_r),
    .keep        (keep),
    .ctl_r       (ctl)
  );

  for (genvar g = 0; g < ipd_pkg::LANES; g++) begin : g_lane
    ipd_lane u_lane (
      .clk    (clk),
      .load   (in_fire),
      .keep   (keep[g]),
      .a      (a_arr[g]),
      .b      (b_arr[g]),
      .prod_r (prod[g])
    );
  end

  ipd_merge u_merge (
    .clk  (clk),
    .load (move12),
    .prod (prod),
    .ctl  (ctl),
    .s2_r (s2)
  );

  ipd_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_fire (acc_fire),
    .out_load (out_load),
    .use_pend (use_pend),
    .s2       (s2),
    .dist_r   (out_ch.distance),
    .tl_r     (out_ch.too_long)
  );

`ifndef SYNTH
  // input stalls only when both front stages are occupied
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r))
    else $error("input stalled with a free pipeline stage");

  // accumulator holds an item only behind a full, blocked result path
  a_acc_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !acc_fire) |-> (cv_r && ov_r && !out_ch.ready))
    else $error("accumulator stalled without downstream backpressure");

  a_cand_load: assert property (@(posedge clk) disable iff (!rst_n)
    cand_in |=> cv_r)
    else $error("last item result lost at candidate register");
`endif

endmodule
`default_nettype wire
